### rtl/csv_row_field_offset_scanner_assert.svh
// ---------------------------------------------------------------------------
// csv row field offset scanner assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef CSV_ROW_FIELD_OFFSET_SCANNER_ASSERT_SVH
`define CSV_ROW_FIELD_OFFSET_SCANNER_ASSERT_SVH

`ifndef SYNTH

// condition must never hold outside reset
`define CSV_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");

// consequent must hold in the same cycle as the antecedent
`define CSV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define CSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define CSV_ASSERT_NEVER(label, clk, rst, cond)
`define CSV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CSV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/csvscan_pkg.sv
// ---------------------------------------------------------------------------
// csvscan_pkg
// shared types and constants of the csv row field offset scanner
// ---------------------------------------------------------------------------
package csvscan_pkg;

   localparam int CHUNK_LEN   = 16;
   localparam int COUNT_W     = 5;
   localparam int BYTE_IDX_W  = 4;
   localparam int POS_W       = 17;
   localparam int OFFSET_W    = 16;
   localparam int FIELD_W     = 8;

   localparam logic [FIELD_W-1:0]  MAX_FIELDS  = 8'd255;
   localparam logic [7:0]          COMMA_CHAR  = 8'h2C;
   localparam logic [7:0]          QUOTE_CHAR  = 8'h22;
   localparam logic [POS_W-1:0]    LINE_LIMIT  = 17'd65534;
   localparam logic [OFFSET_W-1:0] OFFSET_SAT  = 16'hFFFF;
   localparam logic [COUNT_W-1:0]  FULL_COUNT  = 5'd16;

   typedef enum logic [2:0] {
      KIND_FIELD_START = 3'd0,
      KIND_LINE_END    = 3'd1,
      KIND_TOO_MANY    = 3'd2,
      KIND_TOO_FEW     = 3'd3,
      KIND_TOO_LONG    = 3'd4
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MASK,
      ST_EMIT,
      ST_FINAL
   } scan_state_type;

   typedef struct packed {
      logic [CHUNK_LEN-1:0] delim;
      logic                 quote_out;
   } mask_result_type;

endpackage

### rtl/csv_row_field_offset_scanner.sv
// ---------------------------------------------------------------------------
// csv_row_field_offset_scanner
// quote-aware scan of one csv line for field start offsets
// ---------------------------------------------------------------------------
// A line arrives as 16-byte chunks, the final one possibly partial. Each
// chunk is accepted in idle, has its masks built and the line length checked
// in the mask state, then makes its results: one for each comma outside
// quotes and one more for the line end (or too-few error) on the last chunk.
// A too-long chunk reports straight from the mask state. The request side
// is stalled until the sequencer is back in idle.
// All offsets but the saturated too-long one come out of a single shared
// 17-bit adder stepped by the sequencer, so results leave at most one per
// cycle. A stalled result channel holds the sequencer in place. No clearing
// pass after reset.
// ---------------------------------------------------------------------------
`include "csv_row_field_offset_scanner_assert.svh"

module csv_row_field_offset_scanner (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_chunk_low_bytes,
   input  logic [63:0] req_chunk_high_bytes,
   input  logic [4:0]  req_valid_count,
   input  logic        req_last_chunk,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [7:0]  rsp_field_number,
   output logic [15:0] rsp_byte_offset,
   output logic        rsp_last_of_run
);

   localparam int CB = csvscan_pkg::CHUNK_LEN;
   localparam int CW = csvscan_pkg::COUNT_W;
   localparam int IW = csvscan_pkg::BYTE_IDX_W;
   localparam int PW = csvscan_pkg::POS_W;
   localparam int OW = csvscan_pkg::OFFSET_W;
   localparam int FW = csvscan_pkg::FIELD_W;

   // configuration register
   logic [FW-1:0] expected_ff, expected_in;
   logic [FW-1:0] want;

   // sequencer and line state
   csvscan_pkg::scan_state_type state_ff, state_in;
   logic [PW-1:0] line_pos_ff, line_pos_in;
   logic [PW-1:0] base_ff, base_in;       // line position before this chunk
   logic [FW-1:0] fields_ff, fields_in;
   logic          quote_ff, quote_in;
   logic          failed_ff, failed_in;
   logic [CB-1:0] delim_ff, delim_in;

   // captured request
   logic [63:0]   low_ff, low_in;
   logic [63:0]   high_ff, high_in;
   logic [CW-1:0] count_ff, count_in;
   logic          last_ff, last_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   csvscan_pkg::result_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [FW-1:0]                  rsp_field_ff, rsp_field_in;
   logic [OW-1:0]                  rsp_offset_ff, rsp_offset_in;
   logic                           rsp_last_ff, rsp_last_in;

   // shared offset adder
   logic [PW-1:0] add_a;
   logic [CW-1:0] add_b;
   logic [PW-1:0] add_sum;

   logic                          can_emit;
   logic                          accept;
   logic [IW-1:0]                 first_idx;
   logic [CB-1:0]                 delim_rest;
   csvscan_pkg::mask_result_type  mask;

   assign want     = (expected_ff > csvscan_pkg::MAX_FIELDS) ? csvscan_pkg::MAX_FIELDS
                                                              : expected_ff;
   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign add_sum  = add_a + PW'(add_b);

   csvscan_mask u_mask (
      .chunk_low  (low_ff),
      .chunk_high (high_ff),
      .count      (count_ff),
      .quote_seed (quote_ff),
      .mask_out   (mask)
   );

   // lowest pending delimiter
   always_comb begin
      first_idx = '0;
      for (int i = CB - 1; i >= 0; i--) begin
         if (delim_ff[i]) begin
            first_idx = IW'(i);
         end
      end
   end

   assign delim_rest = delim_ff & (delim_ff - CB'(1));

   always_comb begin
      state_in      = state_ff;
      expected_in   = csr_wr_en ? csr_wr_data : expected_ff;
      line_pos_in   = line_pos_ff;
      base_in       = base_ff;
      fields_in     = fields_ff;
      quote_in      = quote_ff;
      failed_in     = failed_ff;
      delim_in      = delim_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_field_in  = rsp_field_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_last_in   = rsp_last_ff;
      add_a         = line_pos_ff;
      add_b         = count_ff;
      req_stall     = (state_ff != csvscan_pkg::ST_IDLE);

      case (state_ff)
         csvscan_pkg::ST_IDLE: begin
            if (accept) begin
               low_in   = req_chunk_low_bytes;
               high_in  = req_chunk_high_bytes;
               // counts above a full chunk act as a full chunk
               count_in = (req_valid_count > csvscan_pkg::FULL_COUNT)
                          ? csvscan_pkg::FULL_COUNT : req_valid_count;
               last_in  = req_last_chunk;
               state_in = csvscan_pkg::ST_MASK;
            end
         end

         csvscan_pkg::ST_MASK: begin
            // adder: line position plus chunk length
            add_a = line_pos_ff;
            add_b = count_ff;
            if (failed_ff) begin
               // dropped line: no results, the last chunk only restores state
               if (last_ff) begin
                  line_pos_in = '0;
                  fields_in   = FW'(1);
                  quote_in    = 1'b0;
                  failed_in   = 1'b0;
               end
               state_in = csvscan_pkg::ST_IDLE;
            end else if (add_sum > csvscan_pkg::LINE_LIMIT) begin
               if (can_emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = csvscan_pkg::KIND_TOO_LONG;
                  rsp_field_in  = fields_ff;
                  rsp_offset_in = csvscan_pkg::OFFSET_SAT;
                  rsp_last_in   = 1'b1;
                  if (last_ff) begin
                     line_pos_in = '0;
                     fields_in   = FW'(1);
                     quote_in    = 1'b0;
                     failed_in   = 1'b0;
                  end else begin
                     failed_in = 1'b1;
                  end
                  state_in = csvscan_pkg::ST_IDLE;
               end
            end else begin
               base_in     = line_pos_ff;
               line_pos_in = add_sum;
               quote_in    = mask.quote_out;
               delim_in    = mask.delim;
               if (mask.delim != '0) begin
                  state_in = csvscan_pkg::ST_EMIT;
               end else if (last_ff) begin
                  state_in = csvscan_pkg::ST_FINAL;
               end else begin
                  state_in = csvscan_pkg::ST_IDLE;
               end
            end
         end

         csvscan_pkg::ST_EMIT: begin
            // adder: chunk base plus delimiter position plus one
            add_a = base_ff;
            add_b = CW'(first_idx) + CW'(1);
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_field_in  = fields_ff;
               rsp_offset_in = add_sum[OW-1:0];
               if (fields_ff >= want) begin
                  // one field too many: report and drop the rest of the line
                  rsp_kind_in = csvscan_pkg::KIND_TOO_MANY;
                  rsp_last_in = 1'b1;
                  delim_in    = '0;
                  if (last_ff) begin
                     line_pos_in = '0;
                     fields_in   = FW'(1);
                     quote_in    = 1'b0;
                     failed_in   = 1'b0;
                  end else begin
                     failed_in = 1'b1;
                  end
                  state_in = csvscan_pkg::ST_IDLE;
               end else begin
                  rsp_kind_in = csvscan_pkg::KIND_FIELD_START;
                  rsp_last_in = (delim_rest == '0) && !last_ff;
                  fields_in   = fields_ff + FW'(1);
                  delim_in    = delim_rest;
                  if (delim_rest == '0) begin
                     state_in = last_ff ? csvscan_pkg::ST_FINAL : csvscan_pkg::ST_IDLE;
                  end
               end
            end
         end

         csvscan_pkg::ST_FINAL: begin
            // adder: line length plus one
            add_a = line_pos_ff;
            add_b = CW'(1);
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = add_sum[OW-1:0];
               rsp_last_in   = 1'b1;
               if (fields_ff != want) begin
                  rsp_kind_in  = csvscan_pkg::KIND_TOO_FEW;
                  rsp_field_in = fields_ff;
               end else begin
                  rsp_kind_in  = csvscan_pkg::KIND_LINE_END;
                  rsp_field_in = want;
               end
               line_pos_in = '0;
               fields_in   = FW'(1);
               quote_in    = 1'b0;
               failed_in   = 1'b0;
               state_in    = csvscan_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = csvscan_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csvscan_pkg::ST_IDLE;
         expected_ff  <= FW'(1);
         line_pos_ff  <= '0;
         fields_ff    <= FW'(1);
         quote_ff     <= 1'b0;
         failed_ff    <= 1'b0;
         delim_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         line_pos_ff  <= line_pos_in;
         fields_ff    <= fields_in;
         quote_ff     <= quote_in;
         failed_ff    <= failed_in;
         delim_ff     <= delim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      count_ff      <= count_in;
      last_ff       <= last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_field_ff  <= rsp_field_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_field_number = rsp_field_ff;
   assign rsp_byte_offset  = rsp_offset_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   // line position never passes the length limit
   `CSV_ASSERT_NEVER(a_pos_limit, clock, reset, line_pos_ff > csvscan_pkg::LINE_LIMIT)

   // the emit state always has a delimiter pending
   `CSV_ASSERT_IMPLIES(a_emit_pending, clock, reset,
      state_ff == csvscan_pkg::ST_EMIT, delim_ff != '0)

   // line end and error results always close the chunk's run
   `CSV_ASSERT_IMPLIES(a_close_run, clock, reset,
      rsp_valid && rsp_result_kind != csvscan_pkg::KIND_FIELD_START, rsp_last_of_run)

   // a delivered line end leaves the line state restored
   `CSV_ASSERT_NEXT(a_final_clear, clock, reset,
      state_ff == csvscan_pkg::ST_FINAL && can_emit,
      line_pos_ff == '0 && fields_ff == FW'(1) && !failed_ff && !quote_ff)

endmodule

### rtl/csvscan_mask.sv
// ---------------------------------------------------------------------------
// csvscan_mask
// comma and quote masks of one chunk, prefix xor for quoted bytes
// ---------------------------------------------------------------------------
module csvscan_mask (
   input  logic [63:0]                        chunk_low,
   input  logic [63:0]                        chunk_high,
   input  logic [csvscan_pkg::COUNT_W-1:0]    count,
   input  logic                               quote_seed,
   output csvscan_pkg::mask_result_type       mask_out
);

   logic [8*csvscan_pkg::CHUNK_LEN-1:0] bytes;
   logic [csvscan_pkg::CHUNK_LEN-1:0]   commas;
   logic [csvscan_pkg::CHUNK_LEN-1:0]   quotes;
   logic [csvscan_pkg::CHUNK_LEN-1:0]   p1, p2, p3, p4, in_quotes;
   logic [csvscan_pkg::BYTE_IDX_W-1:0]  last_idx;

   assign bytes = {chunk_high, chunk_low};

   always_comb begin
      for (int i = 0; i < csvscan_pkg::CHUNK_LEN; i++) begin
         commas[i] = (5'(i) < count) && (bytes[8*i +: 8] == csvscan_pkg::COMMA_CHAR);
         quotes[i] = (5'(i) < count) && (bytes[8*i +: 8] == csvscan_pkg::QUOTE_CHAR);
      end
   end

   // log-depth prefix xor
   always_comb begin
      p1        = quotes ^ (quotes << 1);
      p2        = p1 ^ (p1 << 2);
      p3        = p2 ^ (p2 << 4);
      p4        = p3 ^ (p3 << 8);
      in_quotes = p4 ^ {csvscan_pkg::CHUNK_LEN{quote_seed}};
   end

   assign last_idx           = csvscan_pkg::BYTE_IDX_W'(count - 5'd1);
   assign mask_out.delim     = commas & ~in_quotes;
   assign mask_out.quote_out = (count != '0) ? in_quotes[last_idx] : quote_seed;

endmodule
